// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// condition that must hold in the cycle after reset is seen
`define ASSERT_AFTER_RESET(lbl, clk, rst, cons, msg) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pie_pkg.sv =====
package pie_pkg;

  // default sizes
  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int MAX_ROW_WIDTH_DEF   = 4096;
  localparam int MAX_ROWS_DEF        = 4096;

  // field widths
  localparam int IDX_W      = 8;
  localparam int PIXEL_W    = 32;
  localparam int BYTE_W     = 8;
  localparam int S_TDATA_W  = IDX_W + PIXEL_W + BYTE_W;
  localparam int ROW_CFG_W  = 13;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int M_TUSER_W  = 2;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    DEPTH_1 = 2'd0,
    DEPTH_2 = 2'd1,
    DEPTH_4 = 2'd2,
    DEPTH_8 = 2'd3
  } depth_t;

  typedef enum logic [1:0] {
    FMT_16 = 2'd0,
    FMT_24 = 2'd1,
    FMT_32 = 2'd2
  } fmt_t;

  typedef enum logic [1:0] {
    REG_INDEX_DEPTH = 2'd0,
    REG_OUT_FORMAT  = 2'd1,
    REG_ROW_WIDTH   = 2'd2,
    REG_ROW_COUNT   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_PIXELS = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   idx;
    logic [PIXEL_W-1:0] value;
    logic [BYTE_W-1:0]  src;
  } cmd_t;

  typedef struct packed {
    depth_t               index_depth;
    fmt_t                 out_format;
    logic [ROW_CFG_W-1:0] row_width;
    logic [ROW_CFG_W-1:0] row_count;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               last_of_byte;
    logic               end_of_row;
    logic               end_of_frame;
  } pix_t;

endpackage

// ===== rtl/pie_front.sv =====
module pie_front #(
  parameter int PALETTE_ENTRIES = pie_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pal_index, pal_value, src_byte (lowest first)
  input  logic [pie_pkg::S_TDATA_W-1:0]  s_tdata,
  // op
  input  logic                           s_tuser,
  output logic                           q_valid,
  input  logic                           q_ready,
  output pie_pkg::cmd_t                  q_data
);
  import pie_pkg::*;

  localparam int CMP_W = IDX_W + 1;

  cmd_kind_t kind;
  logic      in_range;
  logic      drop;

  // classify the incoming transaction
  always_comb begin
    kind          = cmd_kind_t'(s_tuser);
    q_data.kind   = kind;
    q_data.idx    = s_tdata[IDX_W-1:0];
    q_data.value  = s_tdata[IDX_W +: PIXEL_W];
    q_data.src    = s_tdata[IDX_W+PIXEL_W +: BYTE_W];
    in_range      = {1'b0, s_tdata[IDX_W-1:0]} < CMP_W'(PALETTE_ENTRIES);
    // writes beyond the palette are taken and discarded here
    drop          = (kind == CMD_WRITE) && !in_range;
    q_valid       = s_tvalid && !drop;
    s_tready      = drop ? 1'b1 : q_ready;
  end

endmodule

// ===== rtl/pie_queue.sv =====
module pie_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  pie_pkg::cmd_t  push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output pie_pkg::cmd_t  pop_data
);
  import pie_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/pie_back.sv =====
module pie_back #(
  parameter int PALETTE_ENTRIES = pie_pkg::PALETTE_ENTRIES_DEF,
  parameter int MAX_ROW_WIDTH   = pie_pkg::MAX_ROW_WIDTH_DEF,
  parameter int MAX_ROWS        = pie_pkg::MAX_ROWS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  pie_pkg::cfg_t  cfg,
  input  logic           q_valid,
  output logic           q_ready,
  input  pie_pkg::cmd_t  q_data,
  output logic           m_valid,
  input  logic           m_ready,
  output pie_pkg::pix_t  m_data
);
  import pie_pkg::*;

  localparam int AW     = $clog2(PALETTE_ENTRIES);
  localparam int COL_W  = $clog2(MAX_ROW_WIDTH);
  localparam int ROWC_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RW_W   = $clog2(MAX_ROW_WIDTH + 1);
  localparam int RC_W   = $clog2(MAX_ROWS + 1);
  localparam int WCMP_W = (RW_W > ROW_CFG_W) ? RW_W : ROW_CFG_W;
  localparam int RCMP_W = (RC_W > ROW_CFG_W) ? RC_W : ROW_CFG_W;
  localparam int ICMP_W = IDX_W + 1;

  // index of the last pixel in a byte for each depth
  function automatic logic [2:0] last_pos(input depth_t d);
    case (d)
      DEPTH_1: last_pos = 3'd7;
      DEPTH_2: last_pos = 3'd3;
      DEPTH_4: last_pos = 3'd1;
      default: last_pos = 3'd0;
    endcase
  endfunction

  // leftmost index held in the top bits
  function automatic logic [IDX_W-1:0] top_index(input depth_t d, input logic [BYTE_W-1:0] b);
    case (d)
      DEPTH_1: top_index = {7'd0, b[7]};
      DEPTH_2: top_index = {6'd0, b[7:6]};
      DEPTH_4: top_index = {4'd0, b[7:4]};
      default: top_index = b;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] next_bits(input depth_t d, input logic [BYTE_W-1:0] b);
    case (d)
      DEPTH_1: next_bits = {b[6:0], 1'b0};
      DEPTH_2: next_bits = {b[5:0], 2'b0};
      DEPTH_4: next_bits = {b[3:0], 4'b0};
      default: next_bits = '0;
    endcase
  endfunction

  function automatic logic [PIXEL_W-1:0] fmt_mask(input fmt_t f);
    case (f)
      FMT_16:  fmt_mask = 32'h0000_FFFF;
      FMT_24:  fmt_mask = 32'h00FF_FFFF;
      default: fmt_mask = 32'hFFFF_FFFF;
    endcase
  endfunction

  // palette store, one write and one registered read port
  logic [PIXEL_W-1:0] palette [PALETTE_ENTRIES];
  logic [PIXEL_W-1:0] rdata;

  // current command
  logic              cur_valid;
  cmd_t              cur;
  logic [BYTE_W-1:0] sh;
  logic [2:0]        k;

  // counters
  logic [COL_W-1:0]  column;
  logic [ROWC_W-1:0] row;

  // output stage
  logic out_oor;
  logic out_lob;
  logic out_eor;
  logic out_eof;

  logic              is_wr;
  logic              is_px;
  logic              advance;
  logic              emit;
  logic              done;
  logic [IDX_W-1:0]  pix_idx;
  logic              pix_oor;
  logic [WCMP_W-1:0] rw_ext;
  logic [WCMP_W-1:0] width_lim;
  logic [WCMP_W-1:0] col_inc;
  logic [RCMP_W-1:0] rc_ext;
  logic [RCMP_W-1:0] rows_lim;
  logic [RCMP_W-1:0] row_inc;
  logic              eor;
  logic              eof;
  logic              lob;

  // width and row limits saturated into range
  always_comb begin
    rw_ext = WCMP_W'(cfg.row_width);
    if (rw_ext == '0) begin
      width_lim = WCMP_W'(1);
    end else if (rw_ext > WCMP_W'(MAX_ROW_WIDTH)) begin
      width_lim = WCMP_W'(MAX_ROW_WIDTH);
    end else begin
      width_lim = rw_ext;
    end
    rc_ext = RCMP_W'(cfg.row_count);
    if (rc_ext == '0) begin
      rows_lim = RCMP_W'(1);
    end else if (rc_ext > RCMP_W'(MAX_ROWS)) begin
      rows_lim = RCMP_W'(MAX_ROWS);
    end else begin
      rows_lim = rc_ext;
    end
  end

  // per-pixel decode
  always_comb begin
    is_wr   = cur_valid && (cur.kind == CMD_WRITE);
    is_px   = cur_valid && (cur.kind == CMD_PIXELS);
    advance = !m_valid || m_ready;
    emit    = is_px && advance;
    pix_idx = top_index(cfg.index_depth, sh);
    pix_oor = {1'b0, pix_idx} >= ICMP_W'(PALETTE_ENTRIES);
    col_inc = WCMP_W'(column) + WCMP_W'(1);
    row_inc = RCMP_W'(row) + RCMP_W'(1);
    eor     = col_inc >= width_lim;
    eof     = eor && (row_inc >= rows_lim);
    // padding pixels after a row end are skipped by closing the byte
    lob     = eor || (k == last_pos(cfg.index_depth));
    done    = is_wr || (emit && lob);
    q_ready = !cur_valid || done;
  end

  // palette write and read
  always_ff @(posedge clk) begin
    if (is_wr) begin
      palette[cur.idx[AW-1:0]] <= cur.value;
    end
    if (emit) begin
      rdata <= palette[pix_idx[AW-1:0]];
    end
  end

  // command sequencing
  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      cur <= q_data;
      sh  <= q_data.src;
      k   <= '0;
    end else if (emit) begin
      sh  <= next_bits(cfg.index_depth, sh);
      k   <= k + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (q_ready) begin
      cur_valid <= q_valid;
    end
  end

  // column and row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (emit) begin
      if (eor) begin
        column <= '0;
        row    <= eof ? '0 : row + ROWC_W'(1);
      end else begin
        column <= column + COL_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_oor <= pix_oor;
      out_lob <= lob;
      out_eor <= eor;
      out_eof <= eof;
    end
  end

  always_comb begin
    m_data.pixel        = out_oor ? '0 : (rdata & fmt_mask(cfg.out_format));
    m_data.last_of_byte = out_lob;
    m_data.end_of_row   = out_eor;
    m_data.end_of_frame = out_eof;
  end

endmodule

// ===== rtl/palette_index_expander_unit.sv =====
// channel   dir  handshake            payload
// s_*       in   s_tvalid / s_tready  tdata: pal_index, pal_value, src_byte; tuser: op
// m_*       out  m_tvalid / m_tready  tdata: pixel; tlast: end_of_row;
//                                     tuser: last_of_byte, end_of_frame
// cfg_*     in   cfg_we               cfg_index, cfg_data
//
// a byte transaction takes one cycle per pixel it emits: 8 at 1 bit, 4, 2, 1 at 8 bit,
// fewer when a row ends inside the byte, and never while m_* stalls
// the pace is set by the back sequencer, which makes one palette read per cycle
// when idle, a taken byte passes the queue slot, current command and output register
// rst is synchronous: it clears queue, counters, config and valid flags, not the palette
// a stall on m_* holds the output register; the queue keeps taking input until full
module palette_index_expander_unit #(
  parameter int PALETTE_ENTRIES = pie_pkg::PALETTE_ENTRIES_DEF,
  parameter int MAX_ROW_WIDTH   = pie_pkg::MAX_ROW_WIDTH_DEF,
  parameter int MAX_ROWS        = pie_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pal_index, pal_value, src_byte (lowest first)
  input  logic [pie_pkg::S_TDATA_W-1:0]  s_tdata,
  // op
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // pixel
  output logic [pie_pkg::PIXEL_W-1:0]    m_tdata,
  output logic                           m_tlast,
  // last_of_byte, end_of_frame (lowest first)
  output logic [pie_pkg::M_TUSER_W-1:0]  m_tuser,
  input  logic                           cfg_we,
  input  logic [pie_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pie_pkg::CFG_W-1:0]      cfg_data
);
  import pie_pkg::*;

  cfg_t cfg;
  logic fq_valid;
  logic fq_ready;
  cmd_t fq_data;
  logic qb_valid;
  logic qb_ready;
  cmd_t qb_data;
  pix_t pix;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.index_depth <= DEPTH_8;
      cfg.out_format  <= FMT_32;
      cfg.row_width   <= ROW_CFG_W'(1);
      cfg.row_count   <= ROW_CFG_W'(1);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_INDEX_DEPTH: cfg.index_depth <= depth_t'(cfg_data[1:0]);
        REG_OUT_FORMAT:  cfg.out_format  <= fmt_t'(cfg_data[1:0]);
        REG_ROW_WIDTH:   cfg.row_width   <= cfg_data[ROW_CFG_W-1:0];
        REG_ROW_COUNT:   cfg.row_count   <= cfg_data[ROW_CFG_W-1:0];
        default:         cfg             <= cfg;
      endcase
    end
  end

  pie_front #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  pie_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  pie_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .MAX_ROW_WIDTH   (MAX_ROW_WIDTH),
    .MAX_ROWS        (MAX_ROWS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (qb_valid),
    .q_ready (qb_ready),
    .q_data  (qb_data),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_data  (pix)
  );

  // output packing
  assign m_tdata = pix.pixel;
  assign m_tlast = pix.end_of_row;
  assign m_tuser = {pix.end_of_frame, pix.last_of_byte};

endmodule

// ===== rtl/pie_checker.sv =====
`include "assert_macros.svh"

module pie_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [pie_pkg::PIXEL_W-1:0]   m_tdata,
  input logic                          m_tlast,
  input logic [pie_pkg::M_TUSER_W-1:0] m_tuser
);
  import pie_pkg::*;

  // stalled transaction stays offered
  `ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped")

  // stalled pixel keeps its value
  `ASSERT_NEXT(a_hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata), "m_tdata moved")

  // frame end only on a row end
  `ASSERT_SAME(a_eof_eor, clk, rst, m_tvalid && m_tuser[1], m_tlast, "frame end without row end")

  // a row end closes its source byte
  `ASSERT_SAME(a_eor_lob, clk, rst, m_tvalid && m_tlast, m_tuser[0], "row end inside byte")

  // nothing offered right after reset
  `ASSERT_AFTER_RESET(a_reset_idle, clk, rst, !m_tvalid, "output valid after reset")

endmodule

bind palette_index_expander_unit pie_checker u_pie_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
